@@ rtl/lmsd_pkg.sv @@
// lmsd_pkg: sizes, codes and the row-select mapping for the LED matrix scan driver
// no dependencies; used by the interfaces, the core and the checker
`timescale 1ns / 1ps

package lmsd_pkg;

  // matrix geometry
  localparam int MODULES     = 17;
  localparam int LINES       = 8;
  localparam int STORE_DEPTH = MODULES * LINES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int MOD_W       = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int LINE_W      = 3;

  // command codes
  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_COMMIT = 2'd2,
    ACT_SCAN   = 2'd3
  } action_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_WR,
    ST_COMMIT,
    ST_COMMIT_END,
    ST_SCAN
  } state_t;

  // line number to row-select code (A2..A0)
  function automatic logic [2:0] row_code_of(input logic [LINE_W-1:0] line);
    logic [2:0] code;
    case (line)
      3'd0:    code = 3'd0;
      3'd1:    code = 3'd2;
      3'd2:    code = 3'd4;
      3'd3:    code = 3'd3;
      3'd4:    code = 3'd6;
      3'd5:    code = 3'd5;
      3'd6:    code = 3'd7;
      3'd7:    code = 3'd1;
      default: code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/lmsd_if.sv @@
// lmsd_if: valid/ready channels for command beats and scan result beats
// depends on lmsd_pkg
`timescale 1ns / 1ps

interface lmsd_in_if
  import lmsd_pkg::*;
  ();
  logic         valid;
  logic         ready;
  action_t      action;
  logic [7:0]   pixel_x;
  logic [2:0]   pixel_y;
  logic         pixel_on;

  modport source (output valid, action, pixel_x, pixel_y, pixel_on, input ready);
  modport sink   (input valid, action, pixel_x, pixel_y, pixel_on, output ready);
endinterface

interface lmsd_out_if
  import lmsd_pkg::*;
  ();
  logic         valid;
  logic         ready;
  logic [2:0]   row_code;
  logic [7:0]   shift_byte;
  logic         latch_after;
  logic         blanking;
  logic         last;

  modport source (output valid, row_code, shift_byte, latch_after, blanking, last,
                  input ready);
  modport sink   (input valid, row_code, shift_byte, latch_after, blanking, last,
                  output ready);
endinterface

@@ rtl/lmsd_ram.sv @@
// lmsd_ram: simple dual-port synchronous RAM, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module lmsd_ram #(
  parameter int DEPTH = 136,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-cycle collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/led_matrix_scan_driver.sv @@
// Scan tick: 2*MODULES result beats (34), the first one through ST_SCAN, the display
// RAM read port and the output register, then one per cycle while the sink is ready.
// Set pixel passes through ST_SET_WR (shadow read-modify-write), clear stays idle,
// commit runs ST_COMMIT then ST_COMMIT_END (one byte copied per cycle through the
// shadow read port). Reset (rst, synchronous): line 0, shadow valid bits and
// display-loaded flag cleared, so both stores read as zero at once; no clearing pass.
`timescale 1ns / 1ps

module led_matrix_scan_driver
  import lmsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lmsd_in_if.sink    cmd,
  lmsd_out_if.source res
);

  localparam logic [MOD_W-1:0]  MOD_LAST  = MOD_W'(MODULES - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_DEPTH - 1);

  state_t state, state_next;

  // control and bookkeeping registers
  logic [LINE_W-1:0]      line;
  logic                   disp_loaded;
  logic [STORE_DEPTH-1:0] sh_valid;
  logic [ADDR_W-1:0]      cnt;
  logic                   v_q;
  logic                   cw_pend;
  logic [ADDR_W-1:0]      cw_addr;
  logic [ADDR_W-1:0]      set_addr;
  logic [7:0]             set_mask;
  logic                   set_on;
  logic [MOD_W-1:0]       sc_mod;
  logic                   sc_blank;
  logic                   sc_done;
  logic                   p;
  logic [MOD_W-1:0]       p_mod;
  logic                   p_blank;
  logic                   res_valid;

  // memory ports
  logic              sh_we;
  logic [7:0]        sh_wdata;
  logic [ADDR_W-1:0] sh_raddr;
  logic [7:0]        sh_rdata;
  logic [ADDR_W-1:0] disp_raddr;
  logic [7:0]        disp_rdata;
  logic [7:0]        disp_wdata;

  // decode and control
  logic              accept;
  logic [4:0]        in_mod;
  logic              in_range;
  logic [ADDR_W-1:0] in_addr;
  logic [7:0]        sh_old;
  logic              slot_free;
  logic              load;
  logic              issue;
  logic              reissue;
  logic              run_end;

  lmsd_ram #(.DEPTH(STORE_DEPTH), .WIDTH(8)) u_shadow (
    .clk   (clk),
    .we    (sh_we),
    .waddr (set_addr),
    .wdata (sh_wdata),
    .raddr (sh_raddr),
    .rdata (sh_rdata)
  );

  lmsd_ram #(.DEPTH(STORE_DEPTH), .WIDTH(8)) u_display (
    .clk   (clk),
    .we    (cw_pend),
    .waddr (cw_addr),
    .wdata (disp_wdata),
    .raddr (disp_raddr),
    .rdata (disp_rdata)
  );

  // command decode
  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign in_mod    = cmd.pixel_x[7:3];
  assign in_range  = (32'(in_mod) < MODULES);
  assign in_addr   = ADDR_W'({in_mod, cmd.pixel_y});

  // shadow read-modify-write, never-written entries read as zero
  assign sh_old     = v_q ? sh_rdata : 8'h00;
  assign sh_wdata   = set_on ? (sh_old | set_mask) : (sh_old & ~set_mask);
  assign sh_raddr   = (state == ST_COMMIT) ? cnt : in_addr;
  assign disp_wdata = v_q ? sh_rdata : 8'h00;

  // scan fetch: re-read the held entry while the output is stalled
  assign slot_free  = !res_valid || res.ready;
  assign load       = (state == ST_SCAN) && p && slot_free;
  assign reissue    = (state == ST_SCAN) && p && !slot_free;
  assign issue      = (state == ST_SCAN) && !sc_done && (!p || slot_free);
  assign run_end    = load && p_blank && (p_mod == MOD_LAST);
  assign disp_raddr = reissue ? ADDR_W'({p_mod, line}) : ADDR_W'({sc_mod, line});

  // next state and write strobes
  always_comb begin
    state_next = state;
    sh_we      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd.action)
            ACT_SET:    state_next = in_range ? ST_SET_WR : ST_IDLE;
            ACT_CLEAR:  state_next = ST_IDLE;
            ACT_COMMIT: state_next = ST_COMMIT;
            ACT_SCAN:   state_next = ST_SCAN;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SET_WR: begin
        sh_we      = 1'b1;
        state_next = ST_IDLE;
      end
      ST_COMMIT: begin
        if (cnt == ADDR_LAST) begin
          state_next = ST_COMMIT_END;
        end
      end
      ST_COMMIT_END: begin
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (run_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // store bookkeeping: valid bits, line, display-loaded flag
  always_ff @(posedge clk) begin
    if (rst) begin
      sh_valid    <= '0;
      line        <= '0;
      disp_loaded <= 1'b0;
    end else begin
      if (accept && cmd.action == ACT_CLEAR) begin
        sh_valid <= '0;
      end else if (sh_we) begin
        sh_valid[set_addr] <= 1'b1;
      end
      if (state == ST_COMMIT_END) begin
        disp_loaded <= 1'b1;
      end
      if (run_end) begin
        line <= line + 1'b1;
      end
    end
  end

  // set pixel capture and commit copy pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      cw_pend <= 1'b0;
    end else begin
      cw_pend <= (state == ST_COMMIT);
    end
    if (accept && cmd.action == ACT_SET) begin
      v_q      <= sh_valid[in_addr];
      set_addr <= in_addr;
      set_mask <= 8'h80 >> cmd.pixel_x[2:0];
      set_on   <= cmd.pixel_on;
    end else if (state == ST_COMMIT) begin
      v_q     <= sh_valid[cnt];
      cw_addr <= cnt;
    end
    if (accept) begin
      cnt <= '0;
    end else if (state == ST_COMMIT) begin
      cnt <= cnt + 1'b1;
    end
  end

  // scan sequencing: byte index and phase, pending read
  always_ff @(posedge clk) begin
    if (rst) begin
      p       <= 1'b0;
      sc_done <= 1'b0;
    end else if (accept) begin
      p       <= 1'b0;
      sc_done <= 1'b0;
    end else begin
      p <= issue || reissue;
      if (issue && sc_mod == MOD_LAST && sc_blank) begin
        sc_done <= 1'b1;
      end
    end
    if (accept) begin
      sc_mod   <= '0;
      sc_blank <= 1'b0;
    end else if (issue) begin
      p_mod   <= sc_mod;
      p_blank <= sc_blank;
      if (sc_mod == MOD_LAST) begin
        sc_mod   <= '0;
        sc_blank <= 1'b1;
      end else begin
        sc_mod <= sc_mod + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
    if (load) begin
      res.row_code    <= row_code_of(line);
      res.shift_byte  <= (p_blank || !disp_loaded) ? 8'h00 : disp_rdata;
      res.latch_after <= (p_mod == MOD_LAST);
      res.blanking    <= p_blank;
      res.last        <= p_blank && (p_mod == MOD_LAST);
    end
  end

  assign res.valid = res_valid;

endmodule

@@ rtl/lmsd_checker.sv @@
// lmsd_checker: port-level assertions for the LED matrix scan driver, bound to the top
// depends on lmsd_pkg and led_matrix_scan_driver
`timescale 1ns / 1ps

module lmsd_checker
  import lmsd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input action_t    cmd_action,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] res_row_code,
  input logic [7:0] res_shift_byte,
  input logic       res_latch_after,
  input logic       res_blanking,
  input logic       res_last
);

  // a stalled beat stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  // a stalled beat keeps its payload
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_shift_byte) && $stable(res_row_code)
      && $stable(res_last))
    else $error("result payload changed while stalled");

  // a scan tick keeps the command side closed in the next cycle
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_action == ACT_SCAN |=> !cmd_ready)
    else $error("command accepted right after a scan tick");

  // blanking beats carry zero bytes
  a_blank_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_blanking |-> res_shift_byte == 8'h00)
    else $error("nonzero byte in blanking group");

  // the closing beat latches and is a blanking beat
  a_last_latch: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_last |-> res_latch_after && res_blanking)
    else $error("last beat without latch or blanking");

endmodule

bind led_matrix_scan_driver lmsd_checker u_lmsd_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .cmd_action      (cmd.action),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_row_code    (res.row_code),
  .res_shift_byte  (res.shift_byte),
  .res_latch_after (res.latch_after),
  .res_blanking    (res.blanking),
  .res_last        (res.last)
);
